// ----- hdl/cps_pkg.sv -----
// ----------------------------------------------------------------------------
// cps_pkg
// Types and constants shared by the charge port supervisor modules.
// ----------------------------------------------------------------------------
package cps_pkg;

  // Input item and result item
  typedef struct packed {
    logic        mode;
    logic [3:0]  port;
    logic [31:0] now_seconds;
    logic [7:0]  fault_bits;
    logic [19:0] power;
    logic        first_in_sweep;
  } cps_in_t;

  typedef struct packed {
    logic [2:0]  port_state;
    logic [3:0]  stop_cause;
    logic        session_ended;
    logic [15:0] minutes_charged;
    logic [19:0] energy_units;
  } cps_out_t;

  // Configuration registers
  typedef struct packed {
    logic [19:0] pull_power_level;
    logic [19:0] full_power_level;
    logic [16:0] full_hold_seconds;
    logic [16:0] port_power_limit;
    logic [23:0] total_power_limit;
  } cps_cfg_t;

  localparam cps_cfg_t CFG_RESET = '{20'd20, 20'd300, 17'd3600, 17'd1000, 24'd8000};

  localparam logic [2:0] CFG_PULL_LEVEL  = 3'd0;
  localparam logic [2:0] CFG_FULL_LEVEL  = 3'd1;
  localparam logic [2:0] CFG_FULL_HOLD   = 3'd2;
  localparam logic [2:0] CFG_PORT_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_TOTAL_LIMIT = 3'd4;

  // Item kinds
  localparam logic ITEM_SAMPLE = 1'b0;
  localparam logic ITEM_START  = 1'b1;

  // Port modes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_UNKNOWN  = 3'd1;
  localparam logic [2:0] MODE_CHARGING = 3'd2;
  localparam logic [2:0] MODE_FULL     = 3'd3;
  localparam logic [2:0] MODE_PULLED   = 3'd4;

  // Stop causes
  localparam logic [3:0] STOP_NONE        = 4'd0;
  localparam logic [3:0] STOP_OVERCURRENT = 4'd1;
  localparam logic [3:0] STOP_OVERVOLTAGE = 4'd2;
  localparam logic [3:0] STOP_SHORT       = 4'd3;
  localparam logic [3:0] STOP_FUSE        = 4'd4;
  localparam logic [3:0] STOP_OVERTEMP    = 4'd5;
  localparam logic [3:0] STOP_PULLED      = 4'd6;
  localparam logic [3:0] STOP_FULL        = 4'd7;
  localparam logic [3:0] STOP_PORT_POWER  = 4'd8;
  localparam logic [3:0] STOP_TOTAL_POWER = 4'd9;

  // Fault bit positions
  localparam int FAULT_OVERCURRENT = 0;
  localparam int FAULT_OVERVOLTAGE = 1;
  localparam int FAULT_SHORT       = 2;
  localparam int FAULT_FUSE        = 3;
  localparam int FAULT_OVERTEMP    = 4;

  // Timing constants in seconds
  localparam logic [31:0] PULL_CHECK_DELAY = 32'd120;
  localparam logic [31:0] PULL_CONFIRM     = 32'd30;
  localparam logic [31:0] MINUTE           = 32'd60;

  // Energy is kept as quotient and remainder of the power sum by ENERGY_DIV
  localparam int          ENERGY_DIV = 6000;
  localparam logic [19:0] ENERGY_MAX = 20'hFFFFF;
  localparam logic [23:0] SUM_MAX    = 24'hFFFFFF;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  localparam int TAG_W      = 8;   // session tag for band counters
  localparam int BAND_IDX_W = 5;   // enough for up to 32 power bands
  localparam int Q10_W      = 17;  // power / 10
  localparam int QE_W       = 8;   // power / ENERGY_DIV
  localparam int RE_W       = 13;  // power % ENERGY_DIV

  localparam logic [TAG_W-1:0] TAG_MAX = '1;

  // Per-port record
  typedef struct packed {
    logic [2:0]       mode;
    logic [3:0]       stop;
    logic [31:0]      session_start;
    logic [31:0]      phase_start;
    logic             false_full;
    logic [31:0]      full_backup;
    logic [31:0]      below_full;
    logic [31:0]      minute_mark;
    logic [15:0]      minute_count;
    logic [19:0]      energy_q;
    logic [RE_W-1:0]  energy_r;
    logic [TAG_W-1:0] tag;
  } cps_rec_t;

  // Values worked out from the port and power fields ahead of the update
  typedef struct packed {
    logic                  in_range;
    logic [Q10_W-1:0]      q10;
    logic [QE_W-1:0]       qe;
    logic [RE_W-1:0]       re;
    logic [BAND_IDX_W-1:0] band;
  } cps_pre_t;

  // Band counter request from the update
  typedef struct packed {
    logic             minute;
    logic [TAG_W-1:0] tag;
  } cps_acct_t;

  // Band counter memory entry
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [15:0]      count;
  } cps_band_t;

endpackage

// ----- hdl/charge_port_supervisor.sv -----
// ----------------------------------------------------------------------------
// charge_port_supervisor
// Per-port charging supervision: faults, plug/full detection, power limits
// and minute accounting, one item per clock while sample_ready is high.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                     Payload
//  sample    sample_valid / sample_ready   sample (cps_in_t)
//  result    result_valid / result_ready   result (cps_out_t)
//  config    cfg_valid / cfg_ready         cfg_index, cfg_data
//
//  One item per clock while sample_ready is high; a result is offered once its item
//  has passed stages 0 to 2 and been buffered. Port records live in a RAM read one
//  stage ahead of the update, with a one-entry bypass so back-to-back items on one
//  port chain. After reset a clearing pass over all PORTS*POWER_BANDS slots zeroes
//  both RAMs with sample_ready low; config writes are taken at all times. Outside
//  it, sample_ready drops only when eight items are in flight or in the buffer.
//
module charge_port_supervisor
  import cps_pkg::*;
#(
  parameter int PORTS       = 16,
  parameter int POWER_BANDS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  cps_in_t     sample,
  output logic        result_valid,
  input  logic        result_ready,
  output cps_out_t    result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int PORT_AW   = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int SLOTS     = PORTS * POWER_BANDS;
  localparam int BAND_AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SWEEP_W   = $clog2(SLOTS + 1);
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int CREDIT_W  = $clog2(OUT_DEPTH + 1);
  localparam int REC_W     = $bits(cps_rec_t);
  localparam int ENTRY_W   = $bits(cps_band_t);

  // Reciprocal multipliers: power/10 and power/6000 (the latter may read low by one)
  localparam logic [19:0] DIV10_MUL     = 20'd838861;
  localparam int          DIV10_SHIFT   = 23;
  localparam logic [14:0] DIV6000_MUL   = 15'd22369;
  localparam int          DIV6000_SHIFT = 27;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cps_cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PULL_LEVEL:  cfg.pull_power_level  <= cfg_data[19:0];
        CFG_FULL_LEVEL:  cfg.full_power_level  <= cfg_data[19:0];
        CFG_FULL_HOLD:   cfg.full_hold_seconds <= cfg_data[16:0];
        CFG_PORT_LIMIT:  cfg.port_power_limit  <= cfg_data[16:0];
        CFG_TOTAL_LIMIT: cfg.total_power_limit <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Clearing pass after reset
  // --------------------------------------------------------------------------
  logic               sweeping;
  logic [SWEEP_W-1:0] sweep_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping  <= 1'b1;
      sweep_idx <= '0;
    end else if (sweeping) begin
      if (sweep_idx == SWEEP_W'(SLOTS - 1)) begin
        sweeping <= 1'b0;
      end
      sweep_idx <= sweep_idx + SWEEP_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Input acceptance against result buffer credits
  // --------------------------------------------------------------------------
  logic [CREDIT_W-1:0] credits;
  logic [CREDIT_W-1:0] credits_next;
  logic                accept;
  logic                pop;

  assign sample_ready = !sweeping && (credits != '0);
  assign accept       = sample_valid && sample_ready;
  assign pop          = result_valid && result_ready;
  assign credits_next = credits + CREDIT_W'(pop) - CREDIT_W'(accept);

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= CREDIT_W'(OUT_DEPTH);
    end else begin
      credits <= credits_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register, reciprocal products and band index
  // --------------------------------------------------------------------------
  logic                  s0_valid;
  cps_in_t               s0_item;
  logic [39:0]           q10_prod;
  logic [34:0]           qe_prod;
  logic [BAND_IDX_W-1:0] s0_band;
  logic                  s0_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
    end
    if (accept) begin
      s0_item <= sample;
    end
  end

  assign q10_prod    = 40'(s0_item.power) * 40'(DIV10_MUL);
  assign qe_prod     = 35'(s0_item.power) * 35'(DIV6000_MUL);
  assign s0_in_range = (32'(s0_item.port) < PORTS);

  // Band is power/1000, held at the top band
  always_comb begin
    s0_band = '0;
    for (int i = 1; i < POWER_BANDS; i++) begin
      if (32'(s0_item.power) >= 32'(i * 1000)) begin
        s0_band = BAND_IDX_W'(i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: remainder correction, port record read
  // --------------------------------------------------------------------------
  logic                  s1_valid;
  cps_in_t               s1_item;
  logic [Q10_W-1:0]      s1_q10;
  logic [QE_W-1:0]       s1_qe_est;
  logic [BAND_IDX_W-1:0] s1_band;
  logic                  s1_in_range;
  logic [20:0]           re_raw;
  logic                  re_fix;
  cps_pre_t              s1_pre;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
    s1_item     <= s0_item;
    s1_q10      <= q10_prod[DIV10_SHIFT +: Q10_W];
    s1_qe_est   <= qe_prod[DIV6000_SHIFT +: QE_W];
    s1_band     <= s0_band;
    s1_in_range <= s0_in_range;
  end

  assign re_raw = 21'(s1_item.power) - 21'(s1_qe_est) * 21'(ENERGY_DIV);
  assign re_fix = (re_raw[13:0] >= 14'(ENERGY_DIV));

  always_comb begin
    s1_pre.in_range = s1_in_range;
    s1_pre.q10      = s1_q10;
    s1_pre.qe       = re_fix ? s1_qe_est + QE_W'(1) : s1_qe_est;
    s1_pre.re       = re_fix ? RE_W'(re_raw[13:0] - 14'(ENERGY_DIV)) : RE_W'(re_raw[13:0]);
    s1_pre.band     = s1_band;
  end

  // --------------------------------------------------------------------------
  // Stage 2: port record update
  // --------------------------------------------------------------------------
  logic               s2_valid;
  cps_in_t            s2_item;
  cps_pre_t           s2_pre;
  logic [PORT_AW-1:0] s2_addr;
  logic [REC_W-1:0]   rec_rdata;
  cps_rec_t           rec_cur;
  cps_rec_t           rec_next;
  logic               rec_we;
  logic [23:0]        sweep_sum;
  logic [23:0]        sweep_sum_next;
  logic               sum_we;
  cps_out_t           upd_result;
  cps_acct_t          acct;

  // Last record write, for an item on the same port right behind
  logic               lw_valid;
  logic [PORT_AW-1:0] lw_addr;
  cps_rec_t           lw_data;

  logic               prt_we;
  logic [PORT_AW-1:0] prt_waddr;
  logic [REC_W-1:0]   prt_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_item <= s1_item;
    s2_pre  <= s1_pre;
  end

  assign s2_addr = PORT_AW'(s2_item.port);
  assign rec_cur = (lw_valid && lw_addr == s2_addr) ? lw_data : cps_rec_t'(rec_rdata);

  cps_update u_update (
    .item           (s2_item),
    .pre            (s2_pre),
    .rec            (rec_cur),
    .cfg            (cfg),
    .sweep_sum      (sweep_sum),
    .rec_next       (rec_next),
    .rec_we         (rec_we),
    .sweep_sum_next (sweep_sum_next),
    .sum_we         (sum_we),
    .result         (upd_result),
    .acct           (acct)
  );

  always_comb begin
    if (sweeping) begin
      prt_we    = (32'(sweep_idx) < PORTS);
      prt_waddr = PORT_AW'(sweep_idx);
      prt_wdata = '0;
    end else begin
      prt_we    = s2_valid && rec_we;
      prt_waddr = s2_addr;
      prt_wdata = REC_W'(rec_next);
    end
  end

  cps_ram #(
    .WIDTH (REC_W),
    .DEPTH (PORTS)
  ) u_port_ram (
    .clk   (clk),
    .we    (prt_we),
    .waddr (prt_waddr),
    .wdata (prt_wdata),
    .raddr (PORT_AW'(s1_item.port)),
    .rdata (rec_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid  <= 1'b0;
      sweep_sum <= '0;
    end else begin
      if (s2_valid && rec_we) begin
        lw_valid <= 1'b1;
      end
      if (s2_valid && sum_we) begin
        sweep_sum <= sweep_sum_next;
      end
    end
    if (s2_valid && rec_we) begin
      lw_addr <= s2_addr;
      lw_data <= rec_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: band minute counters (read in stage 2, written here)
  // --------------------------------------------------------------------------
  logic               s3_valid;
  logic [BAND_AW-1:0] s2_slot;
  logic [BAND_AW-1:0] s3_slot;
  logic [TAG_W-1:0]   s3_tag;
  logic [ENTRY_W-1:0] band_rdata;
  cps_band_t          band_cur;
  cps_band_t          band_new;
  logic [15:0]        band_count;

  logic               blw_valid;
  logic [BAND_AW-1:0] blw_addr;
  cps_band_t          blw_data;

  logic               bnd_we;
  logic [BAND_AW-1:0] bnd_waddr;
  logic [ENTRY_W-1:0] bnd_wdata;

  assign s2_slot = BAND_AW'(32'(s2_item.port) * POWER_BANDS + 32'(s2_pre.band));

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid && acct.minute;
    end
    s3_slot <= s2_slot;
    s3_tag  <= acct.tag;
  end

  assign band_cur = (blw_valid && blw_addr == s3_slot) ? blw_data : cps_band_t'(band_rdata);

  // A tag from an older session reads as a cleared counter
  always_comb begin
    band_count     = (band_cur.tag == s3_tag) ? band_cur.count : '0;
    band_new.tag   = s3_tag;
    band_new.count = (band_count == COUNT_MAX) ? band_count : band_count + 16'd1;
  end

  always_comb begin
    if (sweeping) begin
      bnd_we    = 1'b1;
      bnd_waddr = BAND_AW'(sweep_idx);
      bnd_wdata = '0;
    end else begin
      bnd_we    = s3_valid;
      bnd_waddr = s3_slot;
      bnd_wdata = ENTRY_W'(band_new);
    end
  end

  cps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_band_ram (
    .clk   (clk),
    .we    (bnd_we),
    .waddr (bnd_waddr),
    .wdata (bnd_wdata),
    .raddr (s2_slot),
    .rdata (band_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      blw_valid <= 1'b0;
    end else if (s3_valid) begin
      blw_valid <= 1'b1;
    end
    if (s3_valid) begin
      blw_addr <= s3_slot;
      blw_data <= band_new;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer
  // --------------------------------------------------------------------------
  cps_out_t          out_mem [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr;
  logic [OUT_AW-1:0] rd_ptr;
  logic [OUT_AW:0]   out_count;

  assign result_valid = (out_count != '0);
  assign result       = out_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + OUT_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_AW'(1);
      end
      out_count <= out_count + (OUT_AW + 1)'(s2_valid) - (OUT_AW + 1)'(pop);
    end
    if (s2_valid) begin
      out_mem[wr_ptr] <= upd_result;
    end
  end

endmodule

// ----- hdl/cps_ram.sv -----
// ----------------------------------------------------------------------------
// cps_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/cps_update.sv -----
// ----------------------------------------------------------------------------
// cps_update
// One-item update of a port record: faults, power detection, limits, minutes.
// ----------------------------------------------------------------------------
module cps_update
  import cps_pkg::*;
(
  input  cps_in_t     item,
  input  cps_pre_t    pre,
  input  cps_rec_t    rec,
  input  cps_cfg_t    cfg,
  input  logic [23:0] sweep_sum,
  output cps_rec_t    rec_next,
  output logic        rec_we,
  output logic [23:0] sweep_sum_next,
  output logic        sum_we,
  output cps_out_t    result,
  output cps_acct_t   acct
);

  logic [31:0]      t;
  logic [31:0]      below_new;
  logic [23:0]      sum_base;
  logic [24:0]      sum_wide;
  logic [13:0]      r_wide;
  logic             carry;
  logic [20:0]      q_wide;
  logic             ended;
  logic [TAG_W-1:0] tag_new;

  assign t       = item.now_seconds;
  assign tag_new = (rec.tag == TAG_MAX) ? TAG_W'(1) : rec.tag + TAG_W'(1);

  always_comb begin
    rec_next       = rec;
    rec_we         = 1'b0;
    sweep_sum_next = sweep_sum;
    sum_we         = 1'b0;
    acct           = '0;
    ended          = 1'b0;
    below_new      = rec.below_full;
    sum_base       = sweep_sum;
    sum_wide       = '0;
    r_wide         = '0;
    carry          = 1'b0;
    q_wide         = '0;

    if (!pre.in_range) begin
      rec_we = 1'b0;
    end else if (item.mode == ITEM_START) begin
      rec_we                 = 1'b1;
      rec_next.mode          = MODE_UNKNOWN;
      rec_next.stop          = STOP_NONE;
      rec_next.false_full    = 1'b0;
      rec_next.session_start = t;
      rec_next.phase_start   = t;
      rec_next.minute_mark   = t;
      rec_next.minute_count  = '0;
      rec_next.energy_q      = '0;
      rec_next.energy_r      = '0;
      rec_next.tag           = tag_new;
    end else if (rec.mode == MODE_IDLE) begin
      rec_we              = 1'b1;
      rec_next.false_full = 1'b0;
    end else begin
      rec_we = 1'b1;
      sum_we = 1'b1;
      if (item.first_in_sweep) begin
        sum_base = '0;
      end

      // Faults in priority order, then plug and battery detection
      if (item.fault_bits[FAULT_OVERCURRENT]) begin
        rec_next.stop = STOP_OVERCURRENT;
      end else if (item.fault_bits[FAULT_OVERVOLTAGE]) begin
        rec_next.stop = STOP_OVERVOLTAGE;
      end else if (item.fault_bits[FAULT_SHORT]) begin
        rec_next.stop = STOP_SHORT;
      end else if (item.fault_bits[FAULT_FUSE]) begin
        rec_next.stop = STOP_FUSE;
      end else if (item.fault_bits[FAULT_OVERTEMP]) begin
        rec_next.stop = STOP_OVERTEMP;
      end else if (item.fault_bits == '0 && rec.stop == STOP_NONE) begin
        if (item.power <= cfg.pull_power_level) begin
          if (rec.mode != MODE_PULLED) begin
            rec_next.mode        = MODE_PULLED;
            rec_next.phase_start = t;
          end else if ((t - rec.session_start) >= PULL_CHECK_DELAY &&
                       (t - rec.phase_start) >= PULL_CONFIRM) begin
            rec_next.stop = (item.power == '0) ? STOP_PULLED : STOP_FULL;
          end
        end else if (item.power <= cfg.full_power_level || rec.false_full) begin
          if (rec.mode != MODE_FULL) begin
            rec_next.mode = MODE_FULL;
            if (!rec.false_full) begin
              rec_next.phase_start = t;
              rec_next.full_backup = t;
            end else begin
              rec_next.phase_start = rec.full_backup;
            end
          end else begin
            // Hold full while power stays low; drop false-full after a minute above
            if (item.power < cfg.full_power_level) begin
              below_new = t;
            end
            rec_next.below_full = below_new;
            rec_next.false_full = ((t - below_new) >= MINUTE) ? 1'b0 : 1'b1;
            if ((t - rec.phase_start) >= 32'(cfg.full_hold_seconds)) begin
              rec_next.stop = STOP_FULL;
            end
          end
        end else begin
          rec_next.mode = MODE_CHARGING;
        end
      end

      // Power limits
      if (rec_next.stop == STOP_NONE) begin
        if (cfg.port_power_limit <= pre.q10) begin
          rec_next.stop = STOP_PORT_POWER;
        end
        sum_wide = {1'b0, sum_base} + 25'(pre.q10);
        sum_base = sum_wide[24] ? SUM_MAX : sum_wide[23:0];
        if (cfg.total_power_limit <= sum_base) begin
          rec_next.stop = STOP_TOTAL_POWER;
        end
      end
      sweep_sum_next = sum_base;

      if (rec_next.stop != STOP_NONE) begin
        rec_next.mode = MODE_IDLE;
        ended         = 1'b1;
      end

      // Minute accounting
      if ((t - rec.minute_mark) >= MINUTE) begin
        rec_next.minute_mark = t;
        if (rec.minute_count != COUNT_MAX) begin
          rec_next.minute_count = rec.minute_count + 16'd1;
        end
        r_wide = 14'(rec.energy_r) + 14'(pre.re);
        carry  = (r_wide >= 14'(ENERGY_DIV));
        rec_next.energy_r = carry ? RE_W'(r_wide - 14'(ENERGY_DIV)) : RE_W'(r_wide);
        q_wide = 21'(rec.energy_q) + 21'(pre.qe) + 21'(carry);
        rec_next.energy_q = (q_wide > 21'(ENERGY_MAX)) ? ENERGY_MAX : q_wide[19:0];
        acct.minute = 1'b1;
        acct.tag    = rec.tag;
      end
    end

    if (pre.in_range) begin
      result.port_state      = rec_next.mode;
      result.stop_cause      = rec_next.stop;
      result.session_ended   = ended;
      result.minutes_charged = rec_next.minute_count;
      result.energy_units    = rec_next.energy_q;
    end else begin
      result = '0;
    end
  end

endmodule

// ----- test/charge_port_supervisor_tb.sv -----
// ----------------------------------------------------------------------------
// charge_port_supervisor_tb
// Self-checking bench for the charge port supervisor. A scoreboard class keeps
// its own copy of every port record and the sweep sum, works out the report
// for each accepted item and compares it field by field with what the
// block returns. Directed items cover faults, limits and detection corners;
// random sessions under several register settings follow, with idling on
// both channels and a long result stall that backs up the input.
// ----------------------------------------------------------------------------
module charge_port_supervisor_tb
  import cps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PORTS       = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 200000;

  // Power profile a port follows while its session runs
  typedef enum int {
    DRAW_PULLED,
    DRAW_FULL,
    DRAW_CHARGING
  } draw_t;

  // --------------------------------------------------------------------------
  // Scoreboard: per-port supervision records and the queue of due reports
  // --------------------------------------------------------------------------
  class port_scoreboard;
    cps_cfg_t    cfg;
    logic [2:0]  mode_of      [PORTS];
    logic [3:0]  cause_of     [PORTS];
    logic [31:0] session_t0   [PORTS];
    logic [31:0] phase_t0     [PORTS];
    logic        false_full   [PORTS];
    logic [31:0] full_backup  [PORTS];
    logic [31:0] below_full_t [PORTS];
    logic [31:0] minute_mark  [PORTS];
    logic [15:0] minutes      [PORTS];
    logic [47:0] energy_acc   [PORTS];
    logic [23:0] sweep_sum;
    cps_out_t    due_reports[$];
    int          errors;

    function new();
      errors = 0;
      reset_state();
    endfunction

    function void reset_state();
      cfg = CFG_RESET;
      sweep_sum = '0;
      due_reports.delete();
      for (int i = 0; i < PORTS; i++) begin
        mode_of[i]      = MODE_IDLE;
        cause_of[i]     = STOP_NONE;
        session_t0[i]   = '0;
        phase_t0[i]     = '0;
        false_full[i]   = 1'b0;
        full_backup[i]  = '0;
        below_full_t[i] = '0;
        minute_mark[i]  = '0;
        minutes[i]      = '0;
        energy_acc[i]   = '0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] data);
      case (idx)
        CFG_PULL_LEVEL:  cfg.pull_power_level  = data[19:0];
        CFG_FULL_LEVEL:  cfg.full_power_level  = data[19:0];
        CFG_FULL_HOLD:   cfg.full_hold_seconds = data[16:0];
        CFG_PORT_LIMIT:  cfg.port_power_limit  = data[16:0];
        CFG_TOTAL_LIMIT: cfg.total_power_limit = data;
        default: ;
      endcase
    endfunction

    // Seconds elapsed, modulo 2^32
    function logic [31:0] since(logic [31:0] now_t, logic [31:0] then_t);
      return now_t - then_t;
    endfunction

    function cps_out_t supervise(cps_in_t it);
      cps_out_t    r;
      int          p;
      logic        ended;
      logic [31:0] t;
      logic [19:0] pw;
      logic [16:0] q;
      logic [24:0] sum_wide;
      logic [48:0] acc_wide;
      logic [47:0] e;
      p = it.port;
      t = it.now_seconds;
      pw = it.power;
      ended = 1'b0;
      if (p >= PORTS) return '0;
      if (it.mode == ITEM_START) begin
        // open or restart a session; fault, power and sweep fields are ignored
        mode_of[p]     = MODE_UNKNOWN;
        cause_of[p]    = STOP_NONE;
        false_full[p]  = 1'b0;
        session_t0[p]  = t;
        phase_t0[p]    = t;
        minute_mark[p] = t;
        minutes[p]     = '0;
        energy_acc[p]  = '0;
      end else if (mode_of[p] == MODE_IDLE) begin
        false_full[p] = 1'b0;
      end else begin
        if (it.first_in_sweep) sweep_sum = '0;
        // faults in priority order, then plug and full detection
        if (it.fault_bits[FAULT_OVERCURRENT])      cause_of[p] = STOP_OVERCURRENT;
        else if (it.fault_bits[FAULT_OVERVOLTAGE]) cause_of[p] = STOP_OVERVOLTAGE;
        else if (it.fault_bits[FAULT_SHORT])       cause_of[p] = STOP_SHORT;
        else if (it.fault_bits[FAULT_FUSE])        cause_of[p] = STOP_FUSE;
        else if (it.fault_bits[FAULT_OVERTEMP])    cause_of[p] = STOP_OVERTEMP;
        else if (it.fault_bits == 8'h00 && cause_of[p] == STOP_NONE) begin
          if (pw <= cfg.pull_power_level) begin
            if (mode_of[p] != MODE_PULLED) begin
              mode_of[p]  = MODE_PULLED;
              phase_t0[p] = t;
            end else if (since(t, session_t0[p]) >= PULL_CHECK_DELAY &&
                         since(t, phase_t0[p]) >= PULL_CONFIRM) begin
              cause_of[p] = (pw == 20'd0) ? STOP_PULLED : STOP_FULL;
            end
          end else if (pw <= cfg.full_power_level || false_full[p]) begin
            if (mode_of[p] != MODE_FULL) begin
              mode_of[p] = MODE_FULL;
              if (!false_full[p]) begin
                phase_t0[p]    = t;
                full_backup[p] = t;
              end else begin
                phase_t0[p] = full_backup[p];
              end
            end else begin
              false_full[p] = 1'b1;
              if (pw < cfg.full_power_level) below_full_t[p] = t;
              if (since(t, below_full_t[p]) >= MINUTE) false_full[p] = 1'b0;
              if (since(t, phase_t0[p]) >= {15'd0, cfg.full_hold_seconds})
                cause_of[p] = STOP_FULL;
            end
          end else begin
            mode_of[p] = MODE_CHARGING;
          end
        end
        // port and sweep limits; the sweep limit wins when both trip
        if (cause_of[p] == STOP_NONE) begin
          q = pw / 10;
          if (cfg.port_power_limit <= q) cause_of[p] = STOP_PORT_POWER;
          sum_wide = {1'b0, sweep_sum} + q;
          sweep_sum = (sum_wide > SUM_MAX) ? SUM_MAX : sum_wide[23:0];
          if (cfg.total_power_limit <= sweep_sum) cause_of[p] = STOP_TOTAL_POWER;
        end
        if (cause_of[p] != STOP_NONE) begin
          mode_of[p] = MODE_IDLE;
          ended = 1'b1;
        end
        // minute accounting runs on the ending item too
        if (since(t, minute_mark[p]) >= MINUTE) begin
          minute_mark[p] = t;
          if (minutes[p] != COUNT_MAX) minutes[p] = minutes[p] + 16'd1;
          acc_wide = {1'b0, energy_acc[p]} + pw;
          energy_acc[p] = (acc_wide > {1'b0, {48{1'b1}}}) ? {48{1'b1}} : acc_wide[47:0];
        end
      end
      e = energy_acc[p] / ENERGY_DIV;
      r.port_state      = mode_of[p];
      r.stop_cause      = cause_of[p];
      r.session_ended   = ended;
      r.minutes_charged = minutes[p];
      r.energy_units    = (e > ENERGY_MAX) ? ENERGY_MAX : e[19:0];
      return r;
    endfunction

    function void note_sample(cps_in_t it);
      due_reports.push_back(supervise(it));
    endfunction

    function int pending_count();
      return due_reports.size();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(cps_out_t got);
      cps_out_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: result with nothing due: actual %p", $time, got);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("port_state", want.port_state, got.port_state);
      compare_field("stop_cause", want.stop_cause, got.stop_cause);
      compare_field("session_ended", want.session_ended, got.session_ended);
      compare_field("minutes_charged", want.minutes_charged, got.minutes_charged);
      compare_field("energy_units", want.energy_units, got.energy_units);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block under test
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  cps_in_t     sample = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  cps_out_t    result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_PULL_LEVEL;
  logic [23:0] cfg_data = '0;

  port_scoreboard sb;

  // Stimulus state: a wall clock that moves forward and a profile per port
  logic [31:0] wall = 32'd10000;
  draw_t       profile [PORTS];

  // Pressure controls; the main process writes quiet and holds_asked nonblocking
  logic quiet = 1'b0;
  int   holds_asked = 0;
  int   holds_taken = 0;
  int   hold_left = 0;
  int   cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  charge_port_supervisor #(
    .PORTS      (PORTS),
    .POWER_BANDS(8)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Result side: check each accepted item, then pick the next ready level.
  // A requested hold keeps ready low while hold_left counts down from
  // HOLD_CYCLES, so the result buffer fills and the block stalls its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_report(result);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (holds_taken != holds_asked) begin
      holds_taken <= holds_asked;
      hold_left <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      result_ready <= quiet || ($urandom_range(0, 99) >= 9);
    end
  end

  // Watchdog: end the run if it never drains
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one item, idle first at random, and hold it until accepted.
  // Valid stays high into the next call when no gap follows.
  task automatic send_item(input cps_in_t it);
    int gap;
    gap = 0;
    if (!quiet) while ($urandom_range(0, 99) < 9) gap++;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= it;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    sb.note_sample(it);
  endtask

  // Write all five registers back to back, then drop valid
  task automatic write_settings(input cps_cfg_t c);
    logic [2:0]  idx [5];
    logic [23:0] val [5];
    idx = '{CFG_PULL_LEVEL, CFG_FULL_LEVEL, CFG_FULL_HOLD, CFG_PORT_LIMIT,
            CFG_TOTAL_LIMIT};
    val = '{24'(c.pull_power_level), 24'(c.full_power_level),
            24'(c.full_hold_seconds), 24'(c.port_power_limit), c.total_power_limit};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait for every due report, then let the pipeline settle
  task automatic drain();
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic cps_in_t item_of(logic mode, int port, logic [31:0] t,
                                      logic [7:0] faults, logic [19:0] power,
                                      logic first);
    cps_in_t it;
    it.mode           = mode;
    it.port           = port[3:0];
    it.now_seconds    = t;
    it.fault_bits     = faults;
    it.power          = power;
    it.first_in_sweep = first;
    return it;
  endfunction

  // Build one random item: mostly session traffic on a few ports with power
  // following each port's profile, some starts, and some pure noise.
  function automatic cps_in_t random_item(int first_pct);
    cps_in_t it;
    int      roll, pull_i, full_i, lo, hi;
    roll = $urandom_range(0, 99);
    pull_i = sb.cfg.pull_power_level;
    full_i = sb.cfg.full_power_level;
    wall = wall + $urandom_range(0, 15);
    it = '0;
    it.port = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 3));
    if (roll < 8) begin
      it.mode = ITEM_START;
      it.fault_bits = 8'($urandom);
      it.power = 20'($urandom);
      it.first_in_sweep = 1'($urandom);
    end else if (roll < 88) begin
      // idle ports mostly get a fresh session instead of a wasted sample
      if (sb.mode_of[it.port] == MODE_IDLE && $urandom_range(0, 3) != 0) begin
        it.mode = ITEM_START;
      end else begin
        it.mode = ITEM_SAMPLE;
        if ($urandom_range(0, 7) == 0) profile[it.port] = draw_t'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 3) it.fault_bits = 8'(1 << $urandom_range(0, 4));
        case (profile[it.port])
          DRAW_PULLED: begin
            it.power = ($urandom_range(0, 1) == 0) ? 20'd0 : 20'($urandom_range(0, pull_i));
          end
          DRAW_FULL: begin
            if (full_i > pull_i)
              it.power = ($urandom_range(0, 3) == 0) ? 20'(full_i)
                                                      : 20'($urandom_range(pull_i + 1, full_i));
            else
              it.power = 20'($urandom_range(0, full_i));
          end
          default: begin
            lo = full_i + 1;
            hi = full_i + 5000;
            if (hi > 1048575) hi = 1048575;
            if (lo > hi) lo = hi;
            it.power = 20'($urandom_range(lo, hi));
          end
        endcase
        it.first_in_sweep = ($urandom_range(0, 99) < first_pct);
      end
    end else begin
      // noise: any fields, and now and then a jump of the clock anywhere
      it.mode = ITEM_SAMPLE;
      it.fault_bits = 8'($urandom);
      it.power = 20'($urandom);
      it.first_in_sweep = 1'($urandom);
      if ($urandom_range(0, 1) == 0) wall = $urandom;
    end
    it.now_seconds = wall;
    return it;
  endfunction

  // One random phase under the given settings. Every item sent counts
  // toward the total. The pressure phase holds the result side off at its
  // start and runs a stretch with no idling on either side.
  task automatic run_phase(input cps_cfg_t c, input int items, input int first_pct,
                           input bit pressure);
    cps_in_t it;
    int      n;
    drain();
    write_settings(c);
    if (pressure) holds_asked <= holds_asked + 1;
    n = 0;
    while (n < items) begin
      it = random_item(first_pct);
      n++;
      if (pressure) quiet <= (n >= 200 && n < 350);
      send_item(it);
    end
    sample_valid <= 1'b0;
    quiet <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    for (int i = 0; i < PORTS; i++) profile[i] = DRAW_CHARGING;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    sb.reset_state();

    // Directed items under the reset settings.
    // Start ignores faults and power; faults decode in priority order.
    send_item(item_of(ITEM_START,  1, 32'd1000, 8'hFF, 20'hFFFFF, 1'b1));
    send_item(item_of(ITEM_SAMPLE, 1, 32'd1005, 8'hFF, 20'd500, 1'b0));
    send_item(item_of(ITEM_START,  1, 32'd1010, 8'h00, 20'd0, 1'b0));
    send_item(item_of(ITEM_SAMPLE, 1, 32'd1015, 8'h1E, 20'd500, 1'b0));
    send_item(item_of(ITEM_START,  1, 32'd1020, 8'h00, 20'd0, 1'b0));
    send_item(item_of(ITEM_SAMPLE, 1, 32'd1025, 8'h1C, 20'd500, 1'b0));
    send_item(item_of(ITEM_START,  1, 32'd1030, 8'h00, 20'd0, 1'b0));
    send_item(item_of(ITEM_SAMPLE, 1, 32'd1035, 8'h18, 20'd500, 1'b0));
    send_item(item_of(ITEM_START,  1, 32'd1040, 8'h00, 20'd0, 1'b0));
    send_item(item_of(ITEM_SAMPLE, 1, 32'd1045, 8'h10, 20'd500, 1'b0));
    // Unlisted fault bits skip detection but still hit the limits
    send_item(item_of(ITEM_START,  2, 32'd1100, 8'h00, 20'd0, 1'b0));
    send_item(item_of(ITEM_SAMPLE, 2, 32'd1110, 8'hE0, 20'd500, 1'b1));
    // Sample on an idle port
    send_item(item_of(ITEM_SAMPLE, 3, 32'd1120, 8'h00, 20'd5000, 1'b0));
    // Both limits trip at full power: the sweep limit wins
    send_item(item_of(ITEM_START,  4, 32'd1130, 8'h00, 20'd0, 1'b0));
    send_item(item_of(ITEM_SAMPLE, 4, 32'd1131, 8'h00, 20'hFFFFF, 1'b1));
    // Plug pulled at zero power after the check delay
    send_item(item_of(ITEM_START,  5, 32'd1200, 8'h00, 20'd0, 1'b0));
    send_item(item_of(ITEM_SAMPLE, 5, 32'd1210, 8'h00, 20'd0, 1'b1));
    send_item(item_of(ITEM_SAMPLE, 5, 32'd1400, 8'h00, 20'd0, 1'b0));
    // Full hold expires
    send_item(item_of(ITEM_START,  6, 32'd1500, 8'h00, 20'd0, 1'b0));
    send_item(item_of(ITEM_SAMPLE, 6, 32'd1501, 8'h00, 20'd300, 1'b1));
    send_item(item_of(ITEM_SAMPLE, 6, 32'd5200, 8'h00, 20'd300, 1'b0));
    // Low but nonzero power in the pulled state stops as full
    send_item(item_of(ITEM_START,  7, 32'd1600, 8'h00, 20'd0, 1'b0));
    send_item(item_of(ITEM_SAMPLE, 7, 32'd1700, 8'h00, 20'd10, 1'b1));
    send_item(item_of(ITEM_SAMPLE, 7, 32'd1800, 8'h00, 20'd10, 1'b0));
    // Last port, clock wrapping across a minute
    send_item(item_of(ITEM_START,  15, 32'hFFFF_FFF0, 8'h00, 20'd0, 1'b0));
    send_item(item_of(ITEM_SAMPLE, 15, 32'h0000_0050, 8'h00, 20'd5000, 1'b1));
    sample_valid <= 1'b0;

    // Random phases: typical, all zero, near maximum, then a tight mix
    run_phase('{20'd20, 20'd300, 17'd150, 17'd1000, 24'd8000}, 550, 25, 1'b1);
    run_phase('{20'd0, 20'd0, 17'd0, 17'd0, 24'd0}, 60, 25, 1'b0);
    run_phase('{20'hFFFFF, 20'hFFFFF, 17'd86400, 17'd104857, 24'hFFFFFF}, 400, 0, 1'b0);
    run_phase('{20'd100, 20'd2000, 17'd600, 17'd600, 24'd3000}, 400, 25, 1'b0);

    drain();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- charge_port_supervisor.f -----
hdl/cps_pkg.sv
hdl/cps_ram.sv
hdl/cps_update.sv
hdl/charge_port_supervisor.sv
test/charge_port_supervisor_tb.sv
